>>> rtl/grid_ray_caster_core_macros.svh
// Assertion macros used by the ray caster core.
`ifndef GRID_RAY_CASTER_CORE_MACROS_SVH
`define GRID_RAY_CASTER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define GRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/grc_pkg.sv
// Package with the types and constants of the ray caster.
package grc_pkg;
   localparam int GRID_WIDTH_DEF  = 16;
   localparam int GRID_HEIGHT_DEF = 16;
   localparam int MAX_STEPS_DEF   = 64;
   localparam logic [15:0] MISS_DIST = 16'd51200;
   localparam logic [2:0]  MISS_CODE = 3'd1;
   localparam logic [30:0] DD_ZERO   = 31'h4000_0000;
   localparam logic        OP_WRITE  = 1'b0;
   localparam logic        OP_CAST   = 1'b1;

   // Coefficients of the quarter-wave sine polynomial.
   localparam logic [31:0] SIN_C1 = 32'd1686629713;
   localparam logic [31:0] SIN_C3 = 32'd693598668;
   localparam logic [31:0] SIN_C5 = 32'd85569306;
   localparam logic [31:0] SIN_C7 = 32'd5026995;
   localparam logic [31:0] SIN_C9 = 32'd172272;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_SINE, ST_TRIG, ST_DIVX, ST_DIVY, ST_SIDEX, ST_SIDEY,
      ST_STEP, ST_LOOK, ST_OFF, ST_FRAC, ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic        busy;
      logic [30:0] dividend;
      logic [14:0] divisor;
   } div_req_type;
endpackage

>>> rtl/grid_ray_caster_core.sv
// Top level of the DDA grid ray caster.
// Channel | Direction | Content
// req_    | in        | op, cell_x, cell_y, cell_code, origin_x, origin_y, ray_angle
// rsp_    | out       | distance, hit_side, hit_code, wall_frac
// A cast runs a sine and cosine pass, then two divisions, then one grid step and map
// lookup after another until a cell is hit, or returns a miss when nothing is hit
// within MAX_STEPS steps (64 by default).
// After reset the map is cleared one cell a cycle.
// A result waits in the output register; a write is taken while it waits, a cast is not.
`include "grid_ray_caster_core_macros.svh"
module grid_ray_caster_core
   import grc_pkg::*;
#(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
   parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,  // op
   input  logic [55:0] req_tdata,  // cell_x, cell_y, cell_code, origin_x, origin_y, ray_angle, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // distance, hit_side, hit_code, wall_frac
);
   localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam int SW = $clog2(MAX_STEPS + 1);

   state_type st_ff, st_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [SW-1:0] step_ff, step_in;
   logic [15:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [11:0] ang_ff, ang_in;
   logic [15:0] dx_ff, dx_in, dy_ff, dy_in; // sign, magnitude
   logic [30:0] ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [63:0] sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic signed [9:0] mx_ff, mx_in, my_ff, my_in;
   logic side_ff, side_in, out_ok;
   logic [63:0] d_ff, d_in, off_ff, off_in;
   logic [31:0] rsp_ff, rsp_in;
   logic rv_ff, rv_in;
   logic sn_ff, sn_in;
   logic [2:0] ph_ff, ph_in;
   logic [30:0] x2_ff, x2_in;
   logic [31:0] pr_ff, pr_in;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [2:0] wr_data, rd_data;
   logic accept, div_done;
   logic [30:0] quot;
   div_req_type dreq;
   logic [11:0] sa, ca, ta;
   logic [10:0] tq;
   logic [30:0] xq;
   logic [31:0] mul_a, mul_b, psh, vq;
   logic [63:0] prod;
   logic [14:0] mag;
   logic [12:0] partx, party;
   logic [63:0] r64, w64, base;
   logic [15:0] cmp;

   grc_map_mem #(.DEPTH(DEPTH)) u_mem (.clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data));
   grc_divider u_div (.clock(clock), .reset(reset), .req(dreq), .done(div_done),
      .quotient(quot));

   assign accept = req_tvalid && req_tready;
   assign req_tready = st_ff == ST_IDLE && !(req_tuser == OP_CAST && rv_ff);
   assign sa = ang_ff;
   assign ca = ang_ff + 12'd1024;
   assign ta = sn_ff ? ca : sa;
   assign tq = ta[10] ? 11'd1024 - {1'b0, ta[9:0]} : {1'b0, ta[9:0]};
   assign xq = {tq, 20'd0};

   always_comb begin
      unique case (ph_ff)
         3'd0: begin
            mul_a = {1'b0, xq}; mul_b = {1'b0, xq};
         end
         3'd1: begin
            mul_a = SIN_C9; mul_b = {1'b0, x2_ff};
         end
         3'd2, 3'd3, 3'd4: begin
            mul_a = pr_ff; mul_b = {1'b0, x2_ff};
         end
         default: begin
            mul_a = pr_ff; mul_b = {1'b0, xq};
         end
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);
   assign psh = prod[61:30];
   assign vq = (psh + 32'd32768) >> 16;
   assign mag = (vq > 32'd16384) ? 15'd16384 : vq[14:0];
   assign partx = dx_ff[15] ? {1'b0, ox_ff[11:0]} : 13'd4096 - {1'b0, ox_ff[11:0]};
   assign party = dy_ff[15] ? {1'b0, oy_ff[11:0]} : 13'd4096 - {1'b0, oy_ff[11:0]};
   assign out_ok = mx_ff >= 0 && mx_ff < 10'(GRID_WIDTH) && my_ff >= 0 && my_ff < 10'(GRID_HEIGHT);
   assign rd_addr = AW'(32'(my_in) * GRID_WIDTH + 32'(mx_in));
   assign cmp = side_ff ? dx_ff : dy_ff;
   assign base = {44'd0, side_ff ? ox_ff : oy_ff, 4'd0};
   assign r64 = (d_ff + 64'd32) >> 6;
   assign w64 = cmp[15] ? base - off_ff : base + off_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLEAR: if (clr_ff == AW'(DEPTH - 1)) st_in = ST_IDLE;
         ST_IDLE:  if (accept && req_tuser == OP_CAST) st_in = ST_SINE;
         ST_SINE:  if (ph_ff == 3'd5 && sn_ff) st_in = ST_TRIG;
         ST_TRIG:  st_in = ST_DIVX;
         ST_DIVX:  if (div_done || dx_ff[14:0] == '0) st_in = ST_DIVY;
         ST_DIVY:  if (div_done || dy_ff[14:0] == '0) st_in = ST_SIDEX;
         ST_SIDEX: st_in = ST_SIDEY;
         ST_SIDEY: st_in = ST_STEP;
         ST_STEP:  st_in = (step_ff == SW'(MAX_STEPS)) ? ST_DONE : ST_LOOK;
         ST_LOOK:  st_in = (out_ok && rd_data != 3'd0) ? ST_OFF : ST_STEP;
         ST_OFF:   st_in = ST_FRAC;
         ST_FRAC:  st_in = ST_DONE;
         ST_DONE:  if (!rv_ff) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in = clr_ff; step_in = step_ff; ox_in = ox_ff; oy_in = oy_ff; ang_in = ang_ff;
      dx_in = dx_ff; dy_in = dy_ff; ddx_in = ddx_ff; ddy_in = ddy_ff;
      sdx_in = sdx_ff; sdy_in = sdy_ff; mx_in = mx_ff; my_in = my_ff; side_in = side_ff;
      d_in = d_ff; off_in = off_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      sn_in = sn_ff; ph_in = ph_ff; x2_in = x2_ff; pr_in = pr_ff;
      wr_en = 1'b0; wr_addr = clr_ff; wr_data = 3'd0;
      dreq.start = 1'b0; dreq.busy = 1'b0; dreq.dividend = 31'h4000_0000;
      dreq.divisor = dx_ff[14:0];
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (st_ff)
         ST_CLEAR: begin
            wr_en = 1'b1; clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: if (accept) begin
            if (req_tuser == OP_WRITE) begin
               wr_en = 32'(req_tdata[3:0]) < 32'(GRID_WIDTH) &&
                       32'(req_tdata[7:4]) < 32'(GRID_HEIGHT);
               wr_addr = AW'(32'(req_tdata[7:4]) * GRID_WIDTH + 32'(req_tdata[3:0]));
               wr_data = req_tdata[10:8];
            end else begin
               ox_in = req_tdata[26:11]; oy_in = req_tdata[42:27]; ang_in = req_tdata[54:43];
               ph_in = 3'd0; sn_in = 1'b0;
            end
         end
         ST_SINE: begin
            ph_in = ph_ff + 3'd1;
            unique case (ph_ff)
               3'd0: x2_in = psh[30:0];
               3'd1: pr_in = SIN_C7 - psh;
               3'd2: pr_in = SIN_C5 - psh;
               3'd3: pr_in = SIN_C3 - psh;
               3'd4: pr_in = SIN_C1 - psh;
               default: begin
                  ph_in = 3'd0; sn_in = 1'b1;
                  if (!sn_ff) dy_in = {sa[11] && mag != 15'd0, mag};
                  else dx_in = {ca[11] && mag != 15'd0, mag};
               end
            endcase
         end
         ST_TRIG: begin
            mx_in = 10'(ox_ff[15:12]); my_in = 10'(oy_ff[15:12]);
            step_in = '0; side_in = 1'b0;
            dreq.start = 1'b1;
         end
         ST_DIVX: begin
            dreq.busy = 1'b1;
            if (dx_ff[14:0] == '0) ddx_in = DD_ZERO;
            else if (div_done) ddx_in = quot;
            if (div_done || dx_ff[14:0] == '0) begin
               dreq.start = 1'b1; dreq.divisor = dy_ff[14:0];
            end
         end
         ST_DIVY: begin
            dreq.busy = 1'b1; dreq.divisor = dy_ff[14:0];
            if (dy_ff[14:0] == '0) ddy_in = DD_ZERO;
            else if (div_done) ddy_in = quot;
         end
         ST_SIDEX: sdx_in = (64'(partx) * 64'(ddx_ff)) >> 12;
         ST_SIDEY: sdy_in = (64'(party) * 64'(ddy_ff)) >> 12;
         ST_STEP: if (step_ff != SW'(MAX_STEPS)) begin
            step_in = step_ff + 1'b1;
            if (sdx_ff < sdy_ff) begin
               sdx_in = sdx_ff + 64'(ddx_ff); side_in = 1'b0;
               mx_in = dx_ff[15] ? mx_ff - 10'sd1 : mx_ff + 10'sd1;
            end else begin
               sdy_in = sdy_ff + 64'(ddy_ff); side_in = 1'b1;
               my_in = dy_ff[15] ? my_ff - 10'sd1 : my_ff + 10'sd1;
            end
         end else begin
            rsp_in = {12'd0, MISS_CODE, side_ff, MISS_DIST};
         end
         ST_LOOK: begin
            d_in = side_ff ? sdy_ff - 64'(ddy_ff) : sdx_ff - 64'(ddx_ff);
            rsp_in[19:17] = rd_data;
         end
         ST_OFF: off_in = (d_ff[47:0] * 64'(cmp[14:0])) >> 14;
         ST_FRAC: begin
            rsp_in[15:0] = (r64 > 64'd65535) ? 16'hFFFF : r64[15:0];
            rsp_in[16] = side_ff;
            rsp_in[31:20] = w64[15:4];
         end
         ST_DONE: if (!rv_ff) rv_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; rv_ff <= rv_in;
      end
      step_ff <= step_in; ox_ff <= ox_in; oy_ff <= oy_in; ang_ff <= ang_in;
      dx_ff <= dx_in; dy_ff <= dy_in; ddx_ff <= ddx_in; ddy_ff <= ddy_in;
      sdx_ff <= sdx_in; sdy_ff <= sdy_in; mx_ff <= mx_in; my_ff <= my_in;
      side_ff <= side_in; d_ff <= d_in; off_ff <= off_in; rsp_ff <= rsp_in;
      sn_ff <= sn_in; ph_ff <= ph_in; x2_ff <= x2_in; pr_ff <= pr_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rsp_ff;

   `GRC_ASSERT_IMPL(a_no_accept_busy, clock, reset, st_ff != ST_IDLE, !req_tready, "accept while busy")
   `GRC_ASSERT_NEXT(a_cast_starts, clock, reset, accept && req_tuser == OP_CAST, st_ff == ST_SINE, "cast did not start")
   `GRC_ASSERT_NEXT(a_rsp_holds, clock, reset, rv_ff && !rsp_tready, rv_ff && $stable(rsp_ff), "result dropped")
endmodule

>>> rtl/grc_divider.sv
// Restoring divider, one quotient bit per cycle, for the step increments.
module grc_divider
   import grc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [30:0] quotient
);
   logic [30:0] q_ff, q_in;
   logic [15:0] r_ff, r_in;
   logic [14:0] dv_ff, dv_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [15:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; dv_in = dv_ff; cnt_in = cnt_ff; run_in = run_ff;
      trial = {r_ff[14:0], q_ff[30]};
      if (req.start) begin
         q_in = req.dividend; r_in = '0; dv_in = req.divisor; cnt_in = 5'd30; run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dv_ff}) begin
            r_in = trial - {1'b0, dv_ff};
            q_in = {q_ff[29:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[29:0], 1'b0};
         end
         if (cnt_ff == 5'd0) run_in = 1'b0;
         else cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; dv_ff <= dv_in; cnt_ff <= cnt_in;
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
   end

   assign done = run_ff && cnt_ff == 5'd0 && req.busy;
   assign quotient = {q_ff[29:0], trial >= {1'b0, dv_ff}};
endmodule

>>> rtl/grc_map_mem.sv
// Map memory with a registered synchronous read.
module grc_map_mem
   import grc_pkg::*;
#(
   parameter int DEPTH = GRID_WIDTH_DEF * GRID_HEIGHT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [2:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [2:0]               rd_data
);
   logic [2:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
